@@ src/vertex_rotate_scale_offset_assert.svh @@
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shorthand for the concurrent checks used in the vertex transform block.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_SCALE_OFFSET_ASSERT_SVH
`define VERTEX_ROTATE_SCALE_OFFSET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRSO_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("vertex transform: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VRSO_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("vertex transform: next-cycle check failed");

`endif

@@ src/vrso_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants, register codes and structs of the vertex transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package vrso_pkg;

  localparam int MAP_DIM    = 1024;
  localparam int ANGLE_BITS = 12;

  // Largest usable map size given the 11-bit size registers.
  localparam int DIM_CAP = (MAP_DIM > 2047) ? 2047 : MAP_DIM;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ANGLE_REG_W = 12;

  localparam int XF_STAGES = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH,
    REG_MAP_HEIGHT,
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ZOOM,
    REG_SHIFT_X,
    REG_SHIFT_Y
  } cfg_reg_e;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_LOAD,
    TRIG_SQUARE,
    TRIG_HORNER,
    TRIG_FINAL,
    TRIG_ROUND
  } trig_state_e;

  // Odd sine polynomial in Q30, highest power first.
  localparam logic signed [33:0] SIN_C11 = -34'sd3864;
  localparam int HORNER_STEPS = 5;
  localparam int HORNER_CNT_W = $clog2(HORNER_STEPS);
  localparam logic signed [33:0] SIN_COEF [HORNER_STEPS] = '{
    34'sd172272,
    -34'sd5026995,
    34'sd85569306,
    -34'sd693598668,
    34'sd1686629713
  };

  typedef struct packed {
    logic signed [15:0] sin_x;
    logic signed [15:0] cos_x;
    logic signed [15:0] sin_y;
    logic signed [15:0] cos_y;
  } trig_t;

  typedef struct packed {
    logic                  start;
    logic                  axis;
    logic [ANGLE_BITS-1:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic [10:0] dim_x_m1;
    logic [10:0] dim_y_m1;
    logic [15:0] zoom;
    logic [15:0] shift_x;
    logic [15:0] shift_y;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/vrso_trig.sv @@
// ----------------------------------------------------------------------------
// Vertex transform sine and cosine unit
// Evaluates the quarter-wave sine polynomial with one shared multiplier,
// producing the sine and cosine of one axis angle per request.
// ----------------------------------------------------------------------------
`default_nettype none

module vrso_trig (
  input  logic                clk,
  input  logic                rst,
  input  vrso_pkg::trig_req_t req,
  output logic                busy,
  output vrso_pkg::trig_t     trig
);
  import vrso_pkg::*;

  localparam int QW_BITS = ANGLE_BITS - 2;
  localparam int T_SHIFT = 30 - QW_BITS;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << QW_BITS);
  localparam logic [QW_BITS:0]      QW_FULL = (QW_BITS + 1)'(1 << QW_BITS);
  localparam logic [HORNER_CNT_W-1:0] CNT_LAST = HORNER_CNT_W'(HORNER_STEPS - 1);

  trig_state_e state, state_next;

  logic                    axis;
  logic                    phase;
  logic [ANGLE_BITS-1:0]   ang;
  logic [ANGLE_BITS-1:0]   arg;
  logic [1:0]              quad;
  logic [QW_BITS-1:0]      k;
  logic [QW_BITS:0]        kk;
  logic                    neg_r;
  logic signed [33:0]      t;
  logic signed [33:0]      u;
  logic signed [33:0]      p;
  logic signed [33:0]      mul_a;
  logic signed [33:0]      mul_b;
  logic signed [33:0]      mul_p;
  logic [HORNER_CNT_W-1:0] cnt;
  logic [34:0]             s_rnd;
  logic [19:0]             r_mag;
  logic signed [15:0]      r_pos;
  logic signed [15:0]      r_res;
  logic                    res_we;

  // Product scaled by 2^-30, truncated toward zero.
  function automatic logic signed [33:0] mulq30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic        neg;
    logic [33:0] ua;
    logic [33:0] ub;
    logic [67:0] pr;
    logic [33:0] r;
    neg = a[33] ^ b[33];
    ua  = a[33] ? 34'(-a) : 34'(a);
    ub  = b[33] ? 34'(-b) : 34'(b);
    pr  = ua * ub;
    r   = pr[63:30];
    return neg ? $signed(-r) : $signed(r);
  endfunction

  always_comb begin
    arg  = ang + (phase ? QUARTER : '0);
    quad = arg[ANGLE_BITS-1 -: 2];
    k    = arg[QW_BITS-1:0];
    kk   = quad[0] ? (QW_FULL - {1'b0, k}) : {1'b0, k};
  end

  always_comb begin
    case (state)
      TRIG_SQUARE: begin
        mul_a = t;
        mul_b = t;
      end
      TRIG_FINAL: begin
        mul_a = p;
        mul_b = t;
      end
      default: begin
        mul_a = p;
        mul_b = u;
      end
    endcase
    mul_p = mulq30(mul_a, mul_b);
  end

  always_comb begin
    s_rnd = p[33] ? '0 : (35'(p) + 35'd16384);
    r_mag = s_rnd[34:15];
    r_pos = (r_mag > 20'd32767) ? 16'sd32767 : $signed({1'b0, r_mag[14:0]});
    r_res = neg_r ? -r_pos : r_pos;
  end

  always_comb begin
    state_next = state;
    case (state)
      TRIG_IDLE:   if (req.start) state_next = TRIG_LOAD;
      TRIG_LOAD:   state_next = TRIG_SQUARE;
      TRIG_SQUARE: state_next = TRIG_HORNER;
      TRIG_HORNER: if (cnt == CNT_LAST) state_next = TRIG_FINAL;
      TRIG_FINAL:  state_next = TRIG_ROUND;
      TRIG_ROUND:  state_next = phase ? TRIG_IDLE : TRIG_LOAD;
      default:     state_next = TRIG_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != TRIG_IDLE);
    res_we = (state == TRIG_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRIG_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      if (state == TRIG_IDLE && req.start) begin
        phase <= 1'b0;
      end else if (res_we) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      TRIG_IDLE: begin
        if (req.start) begin
          ang  <= req.angle;
          axis <= req.axis;
        end
      end
      TRIG_LOAD: begin
        t     <= 34'(kk) <<< T_SHIFT;
        neg_r <= quad[1];
      end
      TRIG_SQUARE: begin
        u   <= mul_p;
        p   <= SIN_C11;
        cnt <= '0;
      end
      TRIG_HORNER: begin
        p   <= SIN_COEF[cnt] + mul_p;
        cnt <= cnt + 1'b1;
      end
      TRIG_FINAL: begin
        p <= mul_p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trig.sin_x <= 16'sd0;
      trig.cos_x <= 16'sd32767;
      trig.sin_y <= 16'sd0;
      trig.cos_y <= 16'sd32767;
    end else if (res_we) begin
      case ({axis, phase})
        2'b00:   trig.sin_x <= r_res;
        2'b01:   trig.cos_x <= r_res;
        2'b10:   trig.sin_y <= r_res;
        default: trig.cos_y <= r_res;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/vrso_xform.sv @@
// ----------------------------------------------------------------------------
// Vertex transform pipeline
// Nine-stage datapath: centering, two rotations, zoom, offset and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module vrso_xform (
  input  logic                clk,
  input  logic                rst,
  input  logic                hold,
  input  vrso_pkg::cfg_t      cfg,
  input  vrso_pkg::trig_t     trig,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          col,
  input  logic [9:0]          row,
  input  logic signed [15:0]  height,
  input  logic [23:0]         rgb,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  screen_x,
  output logic signed [31:0]  screen_y,
  output logic signed [24:0]  depth,
  output logic [23:0]         rgb_out
);
  import vrso_pkg::*;

  localparam logic signed [39:0] SAT32_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT32_LO = -40'sd2147483648;
  localparam logic signed [28:0] SAT25_HI = 29'sd16777215;
  localparam logic signed [28:0] SAT25_LO = -29'sd16777216;

  logic [XF_STAGES:1] v;
  logic [XF_STAGES:1] rdy;
  logic               in_fire;

  logic signed [15:0] sx, cx, sy, cy;
  logic signed [16:0] zm;
  logic signed [23:0] sh_x, sh_y;

  logic signed [11:0] s1_px, s1_py;
  logic signed [16:0] s1_pz;
  logic [23:0]        s1_rgb;

  logic signed [27:0] s2_cp, s2_sp;
  logic signed [32:0] s2_sz, s2_cz;
  logic signed [11:0] s2_py;
  logic [23:0]        s2_rgb;

  logic signed [33:0] x1, z1;
  logic signed [33:0] s3_x1, s3_z1;
  logic signed [11:0] s3_py;
  logic [23:0]        s3_rgb;

  logic signed [27:0] s4_a, s4_c;
  logic signed [49:0] s4_b, s4_d;
  logic signed [50:0] s4_xz;
  logic [23:0]        s4_rgb;

  logic signed [50:0] a_sh, c_sh;
  logic signed [51:0] xr;
  logic signed [35:0] xs;
  logic signed [50:0] s5_y2, s5_z2;
  logic signed [36:0] s5_ox;
  logic [23:0]        s5_rgb;

  logic signed [51:0] y2r, z2r;
  logic signed [28:0] dzw;
  logic signed [36:0] s6_y16;
  logic signed [24:0] s6_dz;
  logic signed [31:0] s6_ox;
  logic [23:0]        s6_rgb;

  logic signed [53:0] s7_yz;
  logic signed [24:0] s7_dz;
  logic signed [31:0] s7_ox;
  logic [23:0]        s7_rgb;

  logic signed [54:0] yr;
  logic signed [38:0] ys;
  logic signed [39:0] s8_oy;
  logic signed [24:0] s8_dz;
  logic signed [31:0] s8_ox;
  logic [23:0]        s8_rgb;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > SAT32_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT32_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [24:0] sat25(input logic signed [28:0] x);
    logic signed [24:0] r;
    if (x > SAT25_HI) begin
      r = 25'sh0FF_FFFF;
    end else if (x < SAT25_LO) begin
      r = 25'sh100_0000;
    end else begin
      r = x[24:0];
    end
    return r;
  endfunction

  assign sx   = trig.sin_x;
  assign cx   = trig.cos_x;
  assign sy   = trig.sin_y;
  assign cy   = trig.cos_y;
  assign zm   = $signed({1'b0, cfg.zoom});
  assign sh_x = {cfg.shift_x, 8'h00};
  assign sh_y = {cfg.shift_y, 8'h00};

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    rdy[XF_STAGES] = !v[XF_STAGES] || out_ready;
    for (int i = XF_STAGES - 1; i >= 1; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[1] && !hold;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = v[XF_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_fire;
      for (int i = 2; i <= XF_STAGES; i++) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
    end
  end

  always_comb begin
    x1   = 34'(s2_cp) + 34'(s2_sz);
    z1   = 34'(s2_cz) - 34'(s2_sp);
    a_sh = {{8{s4_a[27]}}, s4_a, 15'b0};
    c_sh = {{8{s4_c[27]}}, s4_c, 15'b0};
    xr   = 52'(s4_xz) + 52'sd32768;
    xs   = xr[51:16];
    y2r  = 52'(s5_y2) + 52'sd16384;
    z2r  = 52'(s5_z2) + 52'sd4194304;
    dzw  = z2r[51:23];
    yr   = 55'(s7_yz) + 55'sd32768;
    ys   = yr[54:16];
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_px  <= $signed({1'b0, col, 1'b0}) - $signed({1'b0, cfg.dim_x_m1});
      s1_py  <= $signed({1'b0, row, 1'b0}) - $signed({1'b0, cfg.dim_y_m1});
      s1_pz  <= {height, 1'b0};
      s1_rgb <= rgb;
    end
    if (rdy[2]) begin
      s2_cp  <= cy * s1_px;
      s2_sz  <= sy * s1_pz;
      s2_cz  <= cy * s1_pz;
      s2_sp  <= sy * s1_px;
      s2_py  <= s1_py;
      s2_rgb <= s1_rgb;
    end
    if (rdy[3]) begin
      s3_x1  <= x1;
      s3_z1  <= z1;
      s3_py  <= s2_py;
      s3_rgb <= s2_rgb;
    end
    if (rdy[4]) begin
      s4_a   <= cx * s3_py;
      s4_b   <= sx * s3_z1;
      s4_c   <= sx * s3_py;
      s4_d   <= cx * s3_z1;
      s4_xz  <= s3_x1 * zm;
      s4_rgb <= s3_rgb;
    end
    if (rdy[5]) begin
      s5_y2  <= a_sh - 51'(s4_b);
      s5_z2  <= c_sh + 51'(s4_d);
      s5_ox  <= 37'(xs) + 37'(sh_x);
      s5_rgb <= s4_rgb;
    end
    if (rdy[6]) begin
      s6_y16 <= y2r[51:15];
      s6_dz  <= sat25(dzw);
      s6_ox  <= sat32(40'(s5_ox));
      s6_rgb <= s5_rgb;
    end
    if (rdy[7]) begin
      s7_yz  <= s6_y16 * zm;
      s7_dz  <= s6_dz;
      s7_ox  <= s6_ox;
      s7_rgb <= s6_rgb;
    end
    if (rdy[8]) begin
      s8_oy  <= 40'(ys) + 40'(sh_y);
      s8_dz  <= s7_dz;
      s8_ox  <= s7_ox;
      s8_rgb <= s7_rgb;
    end
    if (rdy[9]) begin
      screen_x <= s8_ox;
      screen_y <= sat32(s8_oy);
      depth    <= s8_dz;
      rgb_out  <= s8_rgb;
    end
  end

endmodule

`default_nettype wire

@@ src/vertex_rotate_scale_offset.sv @@
// ----------------------------------------------------------------------------
// Vertex rotate, scale and offset: height-map vertex to screen transform.
// One item per cycle through the pipeline while out_ready is high and no angle update runs.
// An angle write starts a sine/cosine update; in_ready and cfg_ready stay low until it ends.
// Reset: size 1x1, angles 0, zoom 1.0, offsets 0, pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_rotate_scale_offset_assert.svh"

module vertex_rotate_scale_offset (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vrso_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vrso_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [9:0]                         col,
  input  logic [9:0]                         row,
  input  logic signed [15:0]                 height,
  input  logic [23:0]                        rgb,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 screen_x,
  output logic signed [31:0]                 screen_y,
  output logic signed [24:0]                 depth,
  output logic [23:0]                        rgb_out
);
  import vrso_pkg::*;

  logic [10:0] map_width;
  logic [10:0] map_height;
  logic [15:0] zoom;
  logic [15:0] shift_x;
  logic [15:0] shift_y;

  logic      cfg_fire;
  logic      angle_wr;
  logic      trig_busy;
  trig_req_t trig_req;
  trig_t     trig_vals;
  cfg_t      cfg;

  function automatic logic [10:0] dim_m1(input logic [10:0] d);
    logic [10:0] r;
    if (d == 11'd0) begin
      r = 11'd0;
    end else if (d > DIM_CAP) begin
      r = 11'(DIM_CAP - 1);
    end else begin
      r = d - 11'd1;
    end
    return r;
  endfunction

  assign cfg_ready = !trig_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign angle_wr  = cfg_fire && (cfg_index inside {REG_ANGLE_X, REG_ANGLE_Y});

  always_comb begin
    trig_req.start = angle_wr;
    trig_req.axis  = (cfg_index == REG_ANGLE_Y);
    trig_req.angle = ANGLE_BITS'(cfg_data[ANGLE_REG_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 11'd1;
      map_height <= 11'd1;
      zoom       <= 16'd256;
      shift_x    <= 16'd0;
      shift_y    <= 16'd0;
    end else if (cfg_fire) begin
      case (cfg_reg_e'(cfg_index))
        REG_MAP_WIDTH:  map_width  <= cfg_data[10:0];
        REG_MAP_HEIGHT: map_height <= cfg_data[10:0];
        REG_ZOOM:       zoom       <= cfg_data;
        REG_SHIFT_X:    shift_x    <= cfg_data;
        REG_SHIFT_Y:    shift_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.dim_x_m1 = dim_m1(map_width);
    cfg.dim_y_m1 = dim_m1(map_height);
    cfg.zoom     = zoom;
    cfg.shift_x  = shift_x;
    cfg.shift_y  = shift_y;
  end

  vrso_trig u_trig (
    .clk  (clk),
    .rst  (rst),
    .req  (trig_req),
    .busy (trig_busy),
    .trig (trig_vals)
  );

  vrso_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .hold      (trig_busy),
    .cfg       (cfg),
    .trig      (trig_vals),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .col       (col),
    .row       (row),
    .height    (height),
    .rgb       (rgb),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .depth     (depth),
    .rgb_out   (rgb_out)
  );

  `VRSO_ASSERT_NEXT(a_angle_write_starts_trig, clk, rst, angle_wr, trig_busy)
  `VRSO_ASSERT_SAME(a_trig_busy_blocks_ports, clk, rst, trig_busy, !in_ready && !cfg_ready)
  `VRSO_ASSERT_NEXT(a_other_write_keeps_idle, clk, rst, cfg_fire && !angle_wr, !trig_busy)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vertex rotate, scale and offset testbench
// Streams height-map vertices through the transform and checks every result
// against a fixed-point model of the rotation, zoom and screen offset. A
// directed list covers reset values, ignored register writes, map size
// clamping, angle wrap and saturation; random phases with fresh register
// settings follow, one steady, the rest with random vertex and result gaps.
// ----------------------------------------------------------------------------

module tb_top;
  import vrso_pkg::*;

  localparam int QUAD_SHIFT = ANGLE_BITS - 2;
  localparam int QUARTER = 1 << QUAD_SHIFT;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = {CFG_IDX_W{1'b1}};
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 244;
  localparam int STEADY_PHASE = 3;

  localparam longint K1 = 1686629713;
  localparam longint K3 = -693598668;
  localparam longint K5 = 85569306;
  localparam longint K7 = -5026995;
  localparam longint K9 = 172272;
  localparam longint K11 = -3864;

  localparam longint SCREEN_MAX = 64'sd2147483647;
  localparam longint SCREEN_MIN = -64'sd2147483648;
  localparam longint DEPTH_MAX = 64'sd16777215;
  localparam longint DEPTH_MIN = -64'sd16777216;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [24:0] depth;
    logic [23:0]        rgb;
  } screen_point_t;

  typedef struct {
    bit                     is_write;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [9:0]             c;
    logic [9:0]             r;
    logic signed [15:0]     h;
    logic [23:0]            color;
    bit                     typed;
    screen_point_t          want;
  } stimulus_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [9:0]             col = '0;
  logic [9:0]             row = '0;
  logic signed [15:0]     height = '0;
  logic [23:0]            rgb = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [31:0]     screen_x;
  logic signed [31:0]     screen_y;
  logic signed [24:0]     depth;
  logic [23:0]            rgb_out;

  logic [10:0]        width_cfg = 11'd1;
  logic [10:0]        height_cfg = 11'd1;
  logic [11:0]        tilt_x_cfg = '0;
  logic [11:0]        tilt_y_cfg = '0;
  logic [15:0]        zoom_cfg = 16'd256;
  logic signed [15:0] offset_x_cfg = '0;
  logic signed [15:0] offset_y_cfg = '0;

  stimulus_row_t stimulus_rows[$];
  screen_point_t screen_points_due[$];
  int            faults = 0;
  bit            steady = 1'b0;

  vertex_rotate_scale_offset dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .col       (col),
    .row       (row),
    .height    (height),
    .rgb       (rgb),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .depth     (depth),
    .rgb_out   (rgb_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Product of two Q30 values, truncated toward zero.
  function automatic longint mul_q30(longint a, longint b);
    longint ma;
    longint mb;
    longint p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint t;
    t = v + (longint'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint quarter_wave(int unsigned k);
    longint t;
    longint u;
    longint acc;
    longint s;
    longint q;
    t = (longint'(k) << 30) >>> QUAD_SHIFT;
    u = mul_q30(t, t);
    acc = K9 + mul_q30(K11, u);
    acc = K7 + mul_q30(acc, u);
    acc = K5 + mul_q30(acc, u);
    acc = K3 + mul_q30(acc, u);
    acc = K1 + mul_q30(acc, u);
    s = mul_q30(acc, t);
    if (s < 0) begin
      s = 0;
    end
    q = (s + (longint'(1) << 14)) >>> 15;
    return (q > 32767) ? 32767 : q;
  endfunction

  function automatic longint sine_q15(int unsigned a);
    int unsigned quad;
    int unsigned k;
    longint v;
    a = a & ((1 << ANGLE_BITS) - 1);
    quad = (a >> QUAD_SHIFT) & 3;
    k = a & (QUARTER - 1);
    if (quad[0]) begin
      k = QUARTER - k;
    end
    v = quarter_wave(k);
    return quad[1] ? -v : v;
  endfunction

  function automatic longint grid_span(logic [10:0] d);
    if (d == 0) begin
      return 1;
    end
    if (d > MAP_DIM) begin
      return MAP_DIM;
    end
    return longint'(d);
  endfunction

  function automatic screen_point_t project_vertex(logic [9:0] vc, logic [9:0] vr,
                                                   logic signed [15:0] vh,
                                                   logic [23:0] vrgb);
    longint px;
    longint py;
    longint pz;
    longint sy;
    longint cy;
    longint sx;
    longint cx;
    longint x1;
    longint z1;
    longint y2;
    longint z2;
    longint y16;
    longint ox;
    longint oy;
    longint dz;
    screen_point_t pt;
    px = 2 * longint'(vc) - (grid_span(width_cfg) - 1);
    py = 2 * longint'(vr) - (grid_span(height_cfg) - 1);
    pz = 2 * longint'(vh);
    sy = sine_q15(tilt_y_cfg);
    cy = sine_q15(tilt_y_cfg + QUARTER);
    sx = sine_q15(tilt_x_cfg);
    cx = sine_q15(tilt_x_cfg + QUARTER);
    x1 = cy * px + sy * pz;
    z1 = cy * pz - sy * px;
    y2 = cx * (py * 32768) - sx * z1;
    z2 = sx * (py * 32768) + cx * z1;
    y16 = round_shift(y2, 15);
    ox = round_shift(x1 * longint'(zoom_cfg), 16) + longint'(offset_x_cfg) * 256;
    oy = round_shift(y16 * longint'(zoom_cfg), 16) + longint'(offset_y_cfg) * 256;
    dz = round_shift(z2, 23);
    ox = clip(ox, SCREEN_MIN, SCREEN_MAX);
    oy = clip(oy, SCREEN_MIN, SCREEN_MAX);
    dz = clip(dz, DEPTH_MIN, DEPTH_MAX);
    pt.screen_x = ox[31:0];
    pt.screen_y = oy[31:0];
    pt.depth = dz[24:0];
    pt.rgb = vrgb;
    return pt;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_setting(cfg_reg_e rg);
    int unsigned dice;
    int lean;
    dice = $urandom_range(0, 3);
    lean = $urandom_range(0, 1) ? 20 : -20;
    case (rg)
      REG_MAP_WIDTH, REG_MAP_HEIGHT: begin
        if (dice == 0) begin
          return 16'($urandom);
        end
        if (dice == 1) begin
          case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'(MAP_DIM);
            default: return 16'd2047;
          endcase
        end
        return 16'($urandom_range(1, MAP_DIM));
      end
      REG_ANGLE_X, REG_ANGLE_Y: begin
        if (dice == 0) begin
          return 16'($urandom);
        end
        if (dice == 1) begin
          return 16'($urandom_range(0, 3) * QUARTER);
        end
        if (dice == 2) begin
          // Close to a quarter turn, where x or y can leave the 32-bit range.
          return 16'(QUARTER * (1 + 2 * int'($urandom_range(0, 1))) + lean);
        end
        return 16'($urandom_range(0, (1 << ANGLE_BITS) - 1));
      end
      REG_ZOOM: begin
        if (dice == 0) begin
          return 16'd0;
        end
        if (dice == 1) begin
          return 16'hFFFF;
        end
        return 16'($urandom);
      end
      default: begin
        if (dice == 0) begin
          return 16'h8000;
        end
        if (dice == 1) begin
          return 16'h7FFF;
        end
        return 16'($urandom);
      end
    endcase
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stimulus_row_t sr;
    sr.is_write = 1'b1;
    sr.reg_idx = idx;
    sr.reg_val = val;
    sr.c = '0;
    sr.r = '0;
    sr.h = '0;
    sr.color = '0;
    sr.typed = 1'b0;
    sr.want = '0;
    stimulus_rows.push_back(sr);
  endfunction

  function automatic void add_vertex(logic [9:0] vc, logic [9:0] vr, logic signed [15:0] vh,
                                     logic [23:0] vrgb);
    stimulus_row_t sr;
    sr.is_write = 1'b0;
    sr.reg_idx = '0;
    sr.reg_val = '0;
    sr.c = vc;
    sr.r = vr;
    sr.h = vh;
    sr.color = vrgb;
    sr.typed = 1'b0;
    sr.want = '0;
    stimulus_rows.push_back(sr);
  endfunction

  function automatic void add_known(logic [9:0] vc, logic [9:0] vr, logic signed [15:0] vh,
                                    logic [23:0] vrgb, logic signed [31:0] x,
                                    logic signed [31:0] y, logic signed [24:0] d);
    add_vertex(vc, vr, vh, vrgb);
    stimulus_rows[$].typed = 1'b1;
    stimulus_rows[$].want = '{x, y, d, vrgb};
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_MAP_WIDTH:  width_cfg = d[10:0];
      REG_MAP_HEIGHT: height_cfg = d[10:0];
      REG_ANGLE_X:    tilt_x_cfg = d[11:0];
      REG_ANGLE_Y:    tilt_y_cfg = d[11:0];
      REG_ZOOM:       zoom_cfg = d;
      REG_SHIFT_X:    offset_x_cfg = d;
      REG_SHIFT_Y:    offset_y_cfg = d;
      default: ;
    endcase
  endfunction

  function automatic void note_fault(string msg);
    faults++;
    if (faults <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Registers change only once every vertex in flight has come out.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (screen_points_due.size() != 0) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    apply_write(idx, val);
  endtask

  task automatic send_vertex(logic [9:0] vc, logic [9:0] vr, logic signed [15:0] vh,
                             logic [23:0] vrgb, bit typed, screen_point_t known);
    cfg_valid <= 1'b0;
    if (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(0, 99) < 30);
    end
    screen_points_due.push_back(typed ? known : project_vertex(vc, vr, vh, vrgb));
    in_valid <= 1'b1;
    col <= vc;
    row <= vr;
    height <= vh;
    rgb <= vrgb;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    screen_point_t want;
    if (!rst && out_valid && out_ready) begin
      if (screen_points_due.size() == 0) begin
        note_fault($sformatf("unexpected item: x %0d y %0d depth %0d rgb %06h",
                             screen_x, screen_y, depth, rgb_out));
      end else begin
        want = screen_points_due.pop_front();
        if (screen_x !== want.screen_x || screen_y !== want.screen_y ||
            depth !== want.depth || rgb_out !== want.rgb) begin
          note_fault($sformatf({"mismatch: expected x %0d y %0d depth %0d rgb %06h, ",
                                "got x %0d y %0d depth %0d rgb %06h"},
                               want.screen_x, want.screen_y, want.depth, want.rgb,
                               screen_x, screen_y, depth, rgb_out));
        end
      end
    end
  end

  initial begin
    cfg_reg_e rg;
    logic [9:0] vc;
    logic [9:0] vr;
    logic signed [15:0] vh;

    add_write(REG_NONE, 16'hFFFF);
    add_known(10'd0, 10'd0, 16'sd0, 24'h000000, 32'sd0, 32'sd0, 25'sd0);
    add_known(10'd0, 10'd0, 16'sd1, 24'hFFFFFF, 32'sd0, 32'sd0, 25'sd256);
    add_known(10'd1, 10'd0, 16'sd0, 24'h123456, 32'sd256, 32'sd0, 25'sd0);
    add_write(REG_SHIFT_X, 16'h7FFF);
    add_write(REG_SHIFT_Y, 16'h8000);
    add_known(10'd0, 10'd0, 16'sd0, 24'h5A5A5A, 32'sd8388352, -32'sd8388608, 25'sd0);
    add_write(REG_MAP_WIDTH, 16'd0);
    add_write(REG_MAP_HEIGHT, 16'hFFFF);
    add_write(REG_ZOOM, 16'd0);
    add_vertex(10'd1023, 10'd1023, 16'sh8000, 24'hA5A5A5);
    add_vertex(10'd0, 10'd0, 16'sh7FFF, 24'h0F0F0F);
    add_vertex(10'd512, 10'd511, -16'sd1, 24'hF0F0F0);
    add_write(REG_MAP_WIDTH, 16'd1024);
    add_write(REG_MAP_HEIGHT, 16'd1);
    add_write(REG_ZOOM, 16'hFFFF);
    add_write(REG_ANGLE_X, 16'hF123);
    add_write(REG_ANGLE_Y, 16'h0400);
    add_vertex(10'd0, 10'd1023, 16'sd1000, 24'h00FF00);
    add_vertex(10'd1023, 10'd0, -16'sd1000, 24'hFF00FF);
    add_vertex(10'd300, 10'd700, -16'sd12345, 24'h3C3C3C);
    add_write(REG_ANGLE_X, 16'(2 * QUARTER));
    add_write(REG_ANGLE_Y, 16'(3 * QUARTER));
    add_vertex(10'd777, 10'd333, 16'sd23456, 24'hC3C3C3);
    add_write(REG_ANGLE_X, 16'(4 * QUARTER - 1));
    add_write(REG_ANGLE_Y, 16'hFFFF);
    add_vertex(10'd5, 10'd1000, 16'sh8000, 24'h0000FF);
    add_write(REG_MAP_WIDTH, 16'd1);
    add_write(REG_ANGLE_X, 16'd0);
    add_write(REG_ANGLE_Y, 16'(3 * QUARTER + 20));
    add_write(REG_SHIFT_X, 16'h7FFF);
    add_vertex(10'd1023, 10'd0, 16'sh8000, 24'h800001);
    add_write(REG_ANGLE_Y, 16'(QUARTER + 20));
    add_write(REG_SHIFT_X, 16'h8000);
    add_vertex(10'd1023, 10'd0, 16'sh8000, 24'h7FFFFE);
    add_write(REG_ANGLE_Y, 16'd0);
    add_write(REG_ANGLE_X, 16'(3 * QUARTER + 20));
    add_write(REG_SHIFT_Y, 16'h7FFF);
    add_vertex(10'd0, 10'd1023, 16'sh7FFF, 24'h555555);
    add_write(REG_ANGLE_X, 16'(QUARTER + 20));
    add_write(REG_SHIFT_Y, 16'h8000);
    add_vertex(10'd0, 10'd1023, 16'sh7FFF, 24'hAAAAAA);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (stimulus_rows[i]) begin
      if (stimulus_rows[i].is_write) begin
        write_reg(stimulus_rows[i].reg_idx, stimulus_rows[i].reg_val);
      end else begin
        send_vertex(stimulus_rows[i].c, stimulus_rows[i].r, stimulus_rows[i].h,
                    stimulus_rows[i].color, stimulus_rows[i].typed, stimulus_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == STEADY_PHASE);
      rg = rg.first();
      do begin
        write_reg(rg, pick_setting(rg));
        rg = rg.next();
      end while (rg != rg.first());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_NONE, 16'($urandom));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        vc = 10'($urandom);
        vr = 10'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          vh = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else begin
          vh = 16'($urandom);
        end
        send_vertex(vc, vr, vh, 24'($urandom), 1'b0, '0);
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (screen_points_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * XF_STAGES) @(posedge clk);
    if (faults == 0 && screen_points_due.size() == 0) begin
      $display("vertex_rotate_scale_offset verification clean");
    end else begin
      $display("vertex_rotate_scale_offset verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vertex_rotate_scale_offset verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/vrso_pkg.sv
src/vrso_trig.sv
src/vrso_xform.sv
src/vertex_rotate_scale_offset.sv
tb/tb_top.sv
